@@ sv/hhd_pkg.sv @@
package hhd_pkg;

   // Frame layout: header, eight field bytes, checksum byte.
   localparam int unsigned FRAME_BYTES = 10;
   localparam int unsigned FIELD_BYTES = 8;
   localparam int unsigned COUNT_W     = 4;

   // Header codes that open a frame.
   localparam logic [7:0] HDR_READ  = 8'h00;
   localparam logic [7:0] HDR_WRITE = 8'h01;

   typedef logic [7:0]         byte_type;
   typedef logic [COUNT_W-1:0] count_type;

   // Index of the checksum byte within the frame.
   localparam count_type LAST_INDEX   = COUNT_W'(FRAME_BYTES - 1);
   localparam count_type FRAME_LIMIT  = COUNT_W'(FRAME_BYTES);
   localparam count_type FIELD_LIMIT  = COUNT_W'(FIELD_BYTES);

endpackage

@@ sv/hhd_ifs.sv @@
// Input channel: one received byte per transaction.
interface hhd_req_if;
   logic              valid;
   logic              ready;
   hhd_pkg::byte_type rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

// Result channel: one decoded frame per transaction.
interface hhd_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] reg_address;
   logic [31:0] reg_value;
   logic [15:0] time_stamp;
   logic        is_write;
   logic        frame_ok;

   modport source (output valid, output reg_address, output reg_value,
                   output time_stamp, output is_write, output frame_ok,
                   input ready);
   modport sink (input valid, input reg_address, input reg_value,
                 input time_stamp, input is_write, input frame_ok,
                 output ready);
endinterface

@@ sv/hhd_cell.sv @@
// One byte of the field shift chain. It takes its neighbor's byte on a shift.
module hhd_cell (
   input  logic              clock,
   input  logic              shift,
   input  hhd_pkg::byte_type d_in,
   output hhd_pkg::byte_type d_out
);
   import hhd_pkg::*;

   byte_type data_ff;
   byte_type data_in;

   // Hold unless the chain advances.
   assign data_in = shift ? d_in : data_ff;

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign d_out = data_ff;

endmodule

@@ sv/header_hunt_xor_frame_deframer.sv @@
// Frame deframer: hunts the byte stream for a header (0x00 read, 0x01 write), then
// collects a ten-byte frame (header, 16-bit address, 32-bit value, 16-bit stamp,
// XOR checksum, all big-endian) and returns one result per frame with the fields
// and frame_ok, set when the ten bytes XOR to zero. A bad frame still yields a
// result with frame_ok low. Bytes are taken one per cycle; the result appears on
// the cycle after the checksum byte is accepted and sits in a single output
// register. Input is stalled only when a checksum byte arrives while a previous
// result is still waiting, so with the result side ready the rate is one byte
// per clock. The field bytes travel through a chain of eight byte cells.
module header_hunt_xor_frame_deframer (
   input logic       clock,
   input logic       reset,
   hhd_req_if.sink   req_chan,
   hhd_rsp_if.source rsp_chan
);
   import hhd_pkg::*;

   count_type   count_ff;
   count_type   count_in;
   byte_type    xor_ff;
   byte_type    xor_in;
   logic        write_ff;
   logic        write_in;
   logic        rsp_valid_ff;
   logic        rsp_valid_in;
   logic [15:0] rsp_address_ff;
   logic [31:0] rsp_value_ff;
   logic [15:0] rsp_stamp_ff;
   logic        rsp_write_ff;
   logic        rsp_ok_ff;

   logic        req_acc;
   logic        hunting;
   logic        is_header;
   logic        shift;
   logic        last;
   byte_type    rx;
   byte_type    chain [FIELD_BYTES+1];

   // Input handshake: only a checksum byte needs room in the output register.
   assign req_chan.ready = !(rsp_valid_ff && !rsp_chan.ready && count_ff == LAST_INDEX);
   assign req_acc        = req_chan.valid && req_chan.ready;
   assign rx             = req_chan.rx_byte;

   // Frame position decode.
   assign hunting   = (count_ff == '0) || (count_ff >= FRAME_LIMIT);
   assign is_header = (rx == HDR_READ) || (rx == HDR_WRITE);
   assign shift     = req_acc && !hunting && (count_ff <= FIELD_LIMIT);
   assign last      = req_acc && !hunting && (count_ff == LAST_INDEX);

   // Field byte chain: new bytes enter at cell zero and move toward the end.
   assign chain[0] = rx;
   for (genvar i = 0; i < FIELD_BYTES; i++) begin : g_cell
      hhd_cell u_cell (
         .clock (clock),
         .shift (shift),
         .d_in  (chain[i]),
         .d_out (chain[i+1])
      );
   end

   // Byte counter, running XOR and header kind.
   always_comb begin
      count_in = count_ff;
      xor_in   = xor_ff;
      write_in = write_ff;
      if (req_acc) begin
         priority if (hunting) begin
            if (is_header) begin
               count_in = COUNT_W'(1);
               xor_in   = rx;
               write_in = rx[0];
            end else begin
               count_in = '0;
            end
         end else if (count_ff == LAST_INDEX) begin
            count_in = '0;
            xor_in   = xor_ff ^ rx;
         end else begin
            count_in = count_ff + COUNT_W'(1);
            xor_in   = xor_ff ^ rx;
         end
      end
   end

   // Output register valid: set by a finished frame, cleared when taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (last) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         xor_ff       <= '0;
         write_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         xor_ff       <= xor_in;
         write_ff     <= write_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload, loaded from the chain when the checksum byte arrives.
   always_ff @(posedge clock) begin
      if (last) begin
         rsp_address_ff <= {chain[8], chain[7]};
         rsp_value_ff   <= {chain[6], chain[5], chain[4], chain[3]};
         rsp_stamp_ff   <= {chain[2], chain[1]};
         rsp_write_ff   <= write_ff;
         rsp_ok_ff      <= ((xor_ff ^ rx) == '0);
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.reg_address = rsp_address_ff;
   assign rsp_chan.reg_value   = rsp_value_ff;
   assign rsp_chan.time_stamp  = rsp_stamp_ff;
   assign rsp_chan.is_write    = rsp_write_ff;
   assign rsp_chan.frame_ok    = rsp_ok_ff;

`ifndef SYNTH
   // The counter never leaves the frame range.
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= LAST_INDEX)
      else $error("byte counter out of range");

   // A result only appears after a checksum byte was taken.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(last))
      else $error("result without a completed frame");

   // A completed frame always leaves a result waiting.
   a_frame_emits: assert property (@(posedge clock) disable iff (reset)
      last |=> rsp_valid_ff)
      else $error("completed frame produced no result");

   // A non-header byte while hunting leaves the block hunting.
   a_hunt_drop: assert property (@(posedge clock) disable iff (reset)
      (req_acc && count_ff == '0 && !is_header) |=> (count_ff == '0))
      else $error("non-header byte opened a frame");

   // A waiting result is never overwritten by a new frame.
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_chan.ready) |-> !last)
      else $error("result overwritten before it was taken");
`endif

endmodule
